// File: rtl/fwf_pkg.sv
// ----------------------------------------------------------------------------
// fwf_pkg: shared types and constants of the fan-beam weighted FIR row filter
// Request and result payloads, function codes, register indexes, cell control.
// ----------------------------------------------------------------------------
package fwf_pkg;

	localparam int MAX_COLUMNS_DEF = 1024;
	localparam int HALF_WIDTH_DEF  = 4;

	// field widths fixed by the interface
	localparam int FUNC_W    = 2;
	localparam int INDEX_W   = 10;
	localparam int VALUE_W   = 16;
	localparam int OCOL_W    = 10;
	localparam int OVAL_W    = 32;
	localparam int COUNT_W   = 11;
	localparam int GAIN_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	// weighted sample and per-tap product widths
	localparam int WS_W   = 17;
	localparam int PROD_W = 33;

	localparam logic [FUNC_W-1:0] FUNC_TAP    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WEIGHT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 1'd1;

	localparam logic [COUNT_W-1:0] COLUMN_COUNT_RST = 11'd1024;
	localparam logic [GAIN_W-1:0]  GAIN_RST         = 16'd0;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic [INDEX_W-1:0]        index;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [OCOL_W-1:0]        out_column;
		logic signed [OVAL_W-1:0] out_value;
	} res_t;

	typedef struct packed {
		logic                      shift;
		logic                      tap_we;
		logic signed [VALUE_W-1:0] tap_data;
	} cell_ctrl_t;

endpackage

// File: rtl/fwf_ram.sv
// ----------------------------------------------------------------------------
// fwf_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fwf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/fwf_cell.sv
// ----------------------------------------------------------------------------
// fwf_cell: one tap of the filter chain
// Holds a kernel tap and one window sample, multiplies them and adds the
// product to the partial sum coming from the previous cell.
// ----------------------------------------------------------------------------
module fwf_cell #(
	parameter int ACC_W = 37
) (
	input  logic                                  clk,
	input  fwf_pkg::cell_ctrl_t                   ctrl,
	input  logic signed [fwf_pkg::WS_W-1:0]       w_in,
	input  logic signed [ACC_W-1:0]               psum_in,
	output logic signed [fwf_pkg::WS_W-1:0]       w_out,
	output logic signed [ACC_W-1:0]               psum_out
);

	logic signed [fwf_pkg::VALUE_W-1:0] tap_q;
	logic signed [fwf_pkg::WS_W-1:0]    win_q;
	logic signed [fwf_pkg::PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]            psum_q;

	always_ff @(posedge clk) begin
		if (ctrl.tap_we) begin
			tap_q <= ctrl.tap_data;
		end
		if (ctrl.shift) begin
			win_q <= w_in;
		end
		prod_q <= tap_q * win_q;
		// partial sum ripples one cell per clock
		psum_q <= psum_in + ACC_W'(prod_q);
	end

	assign w_out    = win_q;
	assign psum_out = psum_q;

endmodule

// File: rtl/fan_weighted_fir_row_filter.sv
// ----------------------------------------------------------------------------
// fan_weighted_fir_row_filter: cosine-weighted fan-beam FIR row filter
// Weights each detector sample by its column cosine, runs it through a
// (2*HALF_WIDTH+1)-tap kernel held in a chain of cells and scales by the gain.
// ----------------------------------------------------------------------------
// Kernel-tap and weight loads are taken in the idle state and leave it idle. A
// detector sample passes through the weight RAM read, the weighting multiply
// (ST_MULT) and the window shift (ST_SHIFT); if it yields no result it then
// returns to idle, else the partial sum ripples down the cell chain (ST_SUM),
// the gain multiply follows (ST_GAIN) and the result register is loaded
// (ST_FIN) once it is free. A result waiting in the output register does
// not hold up the next request until that request has its own result ready.
// ----------------------------------------------------------------------------
module fan_weighted_fir_row_filter #(
	parameter int MAX_COLUMNS = fwf_pkg::MAX_COLUMNS_DEF,
	parameter int HALF_WIDTH  = fwf_pkg::HALF_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  fwf_pkg::req_t                     req,
	output logic                              res_valid,
	input  logic                              res_stall,
	output fwf_pkg::res_t                     res,
	input  logic                              cfg_write,
	input  logic [fwf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fwf_pkg::CFG_DAT_W-1:0]     cfg_data
);

	localparam int TAPS  = 2 * HALF_WIDTH + 1;
	localparam int CW    = $clog2(MAX_COLUMNS + 1);
	localparam int AW    = $clog2(MAX_COLUMNS);
	localparam int XW    = (CW > fwf_pkg::COUNT_W) ? CW : fwf_pkg::COUNT_W;
	localparam int ACC_W = fwf_pkg::PROD_W + $clog2(TAPS);
	localparam int G_W   = ACC_W + fwf_pkg::GAIN_W + 1;
	localparam int RW    = G_W - 15;
	localparam int CNT_W = $clog2(TAPS + 1);

	localparam logic signed [RW-1:0] SAT_HI = RW'(64'sd2147483647);
	localparam logic signed [RW-1:0] SAT_LO = RW'(-64'sd2147483648);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MULT  = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_GAIN  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]                    state_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [CW-1:0]                 counter_q;
	logic [fwf_pkg::COUNT_W-1:0]   column_count_q;
	logic [fwf_pkg::GAIN_W-1:0]    gain_q;
	logic                          res_valid_q;

	logic signed [fwf_pkg::VALUE_W-1:0] val_q;
	logic [CW-1:0]                      col_q;
	logic                               emit_q;
	logic signed [31:0]                 wprod_q;
	logic signed [G_W-1:0]              gprod_q;
	fwf_pkg::res_t                      res_q;

	logic                               accept;
	logic                               is_sample;
	logic [XW-1:0]                      cc_x;
	logic [CW-1:0]                      n;
	logic [CW-1:0]                      inc;
	logic [CW-1:0]                      col;
	logic                               emit;
	logic [fwf_pkg::VALUE_W-1:0]        weight;
	logic signed [32:0]                 wround;
	logic signed [fwf_pkg::WS_W-1:0]    w_new;
	logic signed [G_W-1:0]              ground;
	logic signed [RW-1:0]               rsh;
	logic signed [fwf_pkg::OVAL_W-1:0]  sat;
	logic                               load_res;

	fwf_pkg::cell_ctrl_t                ctrl [TAPS];
	logic signed [fwf_pkg::WS_W-1:0]    w_chain [TAPS+1];
	logic signed [ACC_W-1:0]            p_chain [TAPS+1];

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign is_sample = (req.func == fwf_pkg::FUNC_SAMPLE);

	// effective column count and next column of the row
	always_comb begin
		cc_x = XW'(column_count_q);
		if (cc_x == '0) begin
			n = CW'(1);
		end else if (cc_x > XW'(MAX_COLUMNS)) begin
			n = CW'(MAX_COLUMNS);
		end else begin
			n = CW'(cc_x);
		end
		inc = counter_q + CW'(1);
		col = (inc > n) ? CW'(1) : inc;
		emit = (col >= CW'(TAPS)) && (col < n);
	end

	fwf_ram #(
		.WIDTH (fwf_pkg::VALUE_W),
		.DEPTH (MAX_COLUMNS)
	) u_weights (
		.clk   (clk),
		.we    (accept && (req.func == fwf_pkg::FUNC_WEIGHT) &&
		        (32'(req.index) < MAX_COLUMNS)),
		.waddr (AW'(req.index)),
		.wdata (req.value),
		.re    (accept && is_sample),
		.raddr (AW'(col - CW'(1))),
		.rdata (weight)
	);

	// weighted sample, rounded half up
	assign wround = 33'(wprod_q) + 33'sd16384;
	assign w_new  = wround[31:15];

	assign w_chain[0] = w_new;
	assign p_chain[0] = '0;

	for (genvar m = 0; m < TAPS; m++) begin : g_cell
		always_comb begin
			ctrl[m].shift    = (state_q == ST_SHIFT);
			ctrl[m].tap_we   = accept && (req.func == fwf_pkg::FUNC_TAP) &&
			                   (32'(req.index) == m);
			ctrl[m].tap_data = req.value;
		end

		fwf_cell #(
			.ACC_W (ACC_W)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl[m]),
			.w_in     (w_chain[m]),
			.psum_in  (p_chain[m]),
			.w_out    (w_chain[m+1]),
			.psum_out (p_chain[m+1])
		);
	end

	// gain rounding and saturation
	always_comb begin
		ground = gprod_q + G_W'(32'sd16384);
		rsh    = ground[G_W-1:15];
		if (rsh > SAT_HI) begin
			sat = 32'sh7fffffff;
		end else if (rsh < SAT_LO) begin
			sat = 32'sh80000000;
		end else begin
			sat = rsh[31:0];
		end
	end

	assign load_res = (state_q == ST_FIN) && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			counter_q      <= '0;
			column_count_q <= fwf_pkg::COLUMN_COUNT_RST;
			gain_q         <= fwf_pkg::GAIN_RST;
			res_valid_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					fwf_pkg::CFG_COLUMN_COUNT: column_count_q <= cfg_data[fwf_pkg::COUNT_W-1:0];
					fwf_pkg::CFG_GAIN:         gain_q <= cfg_data;
					default: ;
				endcase
			end

			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && is_sample) begin
						counter_q <= (col >= n) ? '0 : col;
						state_q   <= ST_MULT;
					end
				end
				ST_MULT:  state_q <= ST_SHIFT;
				ST_SHIFT: begin
					cnt_q   <= '0;
					state_q <= emit_q ? ST_SUM : ST_IDLE;
				end
				ST_SUM: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(TAPS)) begin
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: state_q <= ST_FIN;
				ST_FIN: begin
					if (load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_sample) begin
			val_q  <= req.value;
			col_q  <= col;
			emit_q <= emit;
		end
		if (state_q == ST_MULT) begin
			wprod_q <= val_q * $signed(weight);
		end
		if (state_q == ST_GAIN) begin
			gprod_q <= p_chain[TAPS] * $signed({1'b0, gain_q});
		end
		if (load_res) begin
			res_q.out_column <= fwf_pkg::OCOL_W'(col_q - CW'(HALF_WIDTH));
			res_q.out_value  <= sat;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: tb/fan_weighted_fir_row_filter_tb.sv
// ----------------------------------------------------------------------------
// fan_weighted_fir_row_filter_tb: self-checking bench for the weighted FIR row filter
// Loads the tap and weight tables, then runs directed rows (saturation, row wrap
// after a count change, ignored requests, count limits, output backpressure)
// and random rows under three idle patterns, plus a count above the largest row.
// A transaction-level predictor keeps its own tables and window and queues the
// expected result of each accepted sample that yields one; results are compared in order.
// ----------------------------------------------------------------------------
module fan_weighted_fir_row_filter_tb;

	localparam int TAPS           = 2 * fwf_pkg::HALF_WIDTH_DEF + 1;
	localparam logic [fwf_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int HOLD_CYCLES    = 400;
	localparam int SEGMENT_ITEMS  = 64;
	// rows in this bench never go past this column
	localparam int WEIGHT_LOADS   = 128;
	localparam longint SAT_MAX    = 64'sd2147483647;
	localparam longint SAT_MIN    = -64'sd2147483648;

	logic                            clk;
	logic                            arst_n;
	logic                            req_valid;
	logic                            req_stall;
	fwf_pkg::req_t                   req;
	logic                            res_valid;
	logic                            res_stall;
	fwf_pkg::res_t                   res;
	logic                            cfg_write;
	logic [fwf_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [fwf_pkg::CFG_DAT_W-1:0]   cfg_data;

	// predictor state
	logic signed [fwf_pkg::VALUE_W-1:0] tap_coef [TAPS];
	logic signed [fwf_pkg::VALUE_W-1:0] cos_weight [fwf_pkg::MAX_COLUMNS_DEF];
	longint                             wsample_win [TAPS];
	int unsigned                        col_pos;
	logic [fwf_pkg::COUNT_W-1:0]        n_cols;
	logic [fwf_pkg::GAIN_W-1:0]         gain_q16;

	fwf_pkg::res_t expected_results [$];
	fwf_pkg::res_t oldest;
	int   mismatches;
	int   req_gap_pct;
	int   res_stall_pct;
	int   hold_off;

	fan_weighted_fir_row_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// round to nearest, ties toward +inf, then drop 15 fraction bits
	function automatic longint round_q15(input longint x);
		return (x + 64'sd16384) >>> 15;
	endfunction

	function automatic fwf_pkg::req_t make_req(input logic [fwf_pkg::FUNC_W-1:0] f,
			input logic [fwf_pkg::INDEX_W-1:0] i, input logic [fwf_pkg::VALUE_W-1:0] v);
		fwf_pkg::req_t r;
		r.func  = f;
		r.index = i;
		r.value = v;
		return r;
	endfunction

	function automatic logic [fwf_pkg::VALUE_W-1:0] pick_sample();
		case ($urandom_range(15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic predict_filter(input fwf_pkg::req_t r);
		int unsigned   n;
		int unsigned   col;
		int            m;
		longint        acc;
		longint        scaled;
		fwf_pkg::res_t exp_res;
		case (r.func)
			fwf_pkg::FUNC_TAP: begin
				if (r.index < TAPS)
					tap_coef[r.index] = r.value;
			end
			fwf_pkg::FUNC_WEIGHT: begin
				cos_weight[r.index] = r.value;
			end
			fwf_pkg::FUNC_SAMPLE: begin
				n = n_cols;
				if (n < 1)
					n = 1;
				if (n > fwf_pkg::MAX_COLUMNS_DEF)
					n = fwf_pkg::MAX_COLUMNS_DEF;
				// a count lowered mid-row restarts at column 1
				col = col_pos + 1;
				if (col > n)
					col = 1;
				col_pos = (col >= n) ? 0 : col;
				for (m = TAPS - 1; m > 0; m--)
					wsample_win[m] = wsample_win[m-1];
				wsample_win[0] = round_q15(longint'($signed(r.value)) *
					longint'(cos_weight[col-1]));
				if (col >= TAPS && col + 1 <= n) begin
					acc = 0;
					for (m = 0; m < TAPS; m++)
						acc += longint'(tap_coef[m]) * wsample_win[m];
					scaled = round_q15(acc * longint'(gain_q16));
					if (scaled > SAT_MAX)
						scaled = SAT_MAX;
					else if (scaled < SAT_MIN)
						scaled = SAT_MIN;
					exp_res.out_column = fwf_pkg::OCOL_W'(col - fwf_pkg::HALF_WIDTH_DEF);
					exp_res.out_value  = scaled[fwf_pkg::OVAL_W-1:0];
					expected_results.push_back(exp_res);
				end
			end
			default: begin
			end
		endcase
	endtask

	// called and returns just after a falling edge
	task automatic push_request(input fwf_pkg::req_t item);
		while ($urandom_range(99) < req_gap_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req       = item;
		do @(posedge clk); while (req_stall);
		predict_filter(item);
		@(negedge clk);
	endtask

	task automatic wait_for_idle();
		req_valid = 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		// samples without a result may still be in flight
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_register(input logic [fwf_pkg::CFG_IDX_W-1:0] idx,
			input logic [fwf_pkg::CFG_DAT_W-1:0] data);
		wait_for_idle();
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		if (idx == fwf_pkg::CFG_COLUMN_COUNT)
			n_cols = data[fwf_pkg::COUNT_W-1:0];
		else
			gain_q16 = data[fwf_pkg::GAIN_W-1:0];
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic load_tables();
		int i;
		for (i = 0; i < TAPS; i++)
			push_request(make_req(fwf_pkg::FUNC_TAP, fwf_pkg::INDEX_W'(i), 16'h8000));
		for (i = 0; i < WEIGHT_LOADS; i++)
			push_request(make_req(fwf_pkg::FUNC_WEIGHT, fwf_pkg::INDEX_W'(i),
				(i < 10) ? 16'h8000 : 16'($urandom)));
	endtask

	task automatic test_saturation_and_row_wrap();
		// upper data bits set: count takes only its low 11 bits, n = 12
		set_register(fwf_pkg::CFG_COLUMN_COUNT, 16'hF80C);
		set_register(fwf_pkg::CFG_GAIN, 16'hFFFF);
		repeat (10) push_request(make_req(fwf_pkg::FUNC_SAMPLE, 10'h3FF, 16'h8000));
		// counter now past the new row length, next sample is column 1
		set_register(fwf_pkg::CFG_COLUMN_COUNT, 16'd10);
		repeat (9) push_request(make_req(fwf_pkg::FUNC_SAMPLE, 10'h000, 16'h7FFF));
	endtask

	task automatic test_ignored_requests();
		push_request(make_req(FUNC_NONE, 10'h3FF, 16'hFFFF));
		push_request(make_req(fwf_pkg::FUNC_TAP, fwf_pkg::INDEX_W'(TAPS), 16'h1234));
		push_request(make_req(fwf_pkg::FUNC_TAP, 10'h3FF, 16'h7FFF));
	endtask

	task automatic test_column_count_limits();
		set_register(fwf_pkg::CFG_COLUMN_COUNT, 16'd0);
		repeat (2)
			push_request(make_req(fwf_pkg::FUNC_SAMPLE, 10'($urandom), pick_sample()));
		set_register(fwf_pkg::CFG_COLUMN_COUNT, 16'd1);
		repeat (2)
			push_request(make_req(fwf_pkg::FUNC_SAMPLE, 10'($urandom), pick_sample()));
	endtask

	task automatic test_backpressure();
		set_register(fwf_pkg::CFG_COLUMN_COUNT, 16'd10);
		set_register(fwf_pkg::CFG_GAIN, 16'd300);
		@(posedge clk);
		hold_off = HOLD_CYCLES;
		@(negedge clk);
		repeat (40)
			push_request(make_req(fwf_pkg::FUNC_SAMPLE, 10'($urandom), pick_sample()));
	endtask

	task automatic run_random_segment();
		int cnt;
		int done;
		int pick;
		int burst;
		logic [fwf_pkg::GAIN_W-1:0] g;
		case ($urandom_range(7))
			0: cnt = 10;
			1: cnt = 11;
			2: cnt = 16;
			3: cnt = $urandom_range(2, 9);
			4: cnt = 1;
			default: cnt = $urandom_range(10, 40);
		endcase
		set_register(fwf_pkg::CFG_COLUMN_COUNT, 16'(cnt));
		case ($urandom_range(3))
			0: g = 16'hFFFF;
			1: g = 16'h0000;
			2: g = 16'($urandom_range(1, 255));
			default: g = 16'($urandom);
		endcase
		set_register(fwf_pkg::CFG_GAIN, g);
		done = 0;
		while (done < SEGMENT_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				burst = $urandom_range(1, 2 * cnt + 2);
				repeat (burst)
					push_request(make_req(fwf_pkg::FUNC_SAMPLE, 10'($urandom),
						pick_sample()));
				done += burst;
			end else if (pick < 85) begin
				push_request(make_req(fwf_pkg::FUNC_TAP,
					fwf_pkg::INDEX_W'($urandom_range(TAPS - 1)), 16'($urandom)));
				done++;
			end else if (pick < 93) begin
				push_request(make_req(fwf_pkg::FUNC_WEIGHT, 10'($urandom), 16'($urandom)));
				done++;
			end else if (pick < 97) begin
				push_request(make_req(FUNC_NONE, 10'($urandom), 16'($urandom)));
			end else begin
				push_request(make_req(fwf_pkg::FUNC_TAP,
					fwf_pkg::INDEX_W'($urandom_range(1023, TAPS)), 16'($urandom)));
			end
		end
	endtask

	task automatic test_random_traffic();
		int mode;
		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					req_gap_pct   = 12;
					res_stall_pct = 61;
				end
				1: begin
					req_gap_pct   = 61;
					res_stall_pct = 12;
				end
				default: begin
					req_gap_pct   = 0;
					res_stall_pct = 0;
				end
			endcase
			repeat (7) run_random_segment();
		end
	endtask

	task automatic test_count_above_max();
		// 2047 clamps to the largest row
		set_register(fwf_pkg::CFG_COLUMN_COUNT, 16'd2047);
		set_register(fwf_pkg::CFG_GAIN, 16'($urandom_range(1, 4095)));
		repeat (40)
			push_request(make_req(fwf_pkg::FUNC_SAMPLE, 10'($urandom), pick_sample()));
	endtask

	// receiver side: random stall, or a long hold when requested
	always @(negedge clk) begin
		if (hold_off > 0) begin
			res_stall = 1'b1;
			hold_off--;
		end else begin
			res_stall = ($urandom_range(99) < res_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result col %0d val %0d with none pending",
					res.out_column, res.out_value));
			end else begin
				oldest = expected_results.pop_front();
				if (res.out_column !== oldest.out_column)
					report_mismatch($sformatf("out_column got %0d exp %0d",
						res.out_column, oldest.out_column));
				if (res.out_value !== oldest.out_value)
					report_mismatch($sformatf("out_value col %0d got %0d exp %0d",
						oldest.out_column, res.out_value, oldest.out_value));
			end
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin : main
		int i;
		clk           = 1'b0;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		res_stall     = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		req_gap_pct   = 12;
		res_stall_pct = 61;
		hold_off      = 0;
		mismatches    = 0;
		n_cols        = fwf_pkg::COLUMN_COUNT_RST;
		gain_q16      = fwf_pkg::GAIN_RST;
		col_pos       = 0;
		for (i = 0; i < TAPS; i++) begin
			tap_coef[i]    = '0;
			wsample_win[i] = 0;
		end
		for (i = 0; i < fwf_pkg::MAX_COLUMNS_DEF; i++)
			cos_weight[i] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		load_tables();
		test_saturation_and_row_wrap();
		test_ignored_requests();
		test_column_count_limits();
		test_backpressure();
		test_random_traffic();
		test_count_above_max();

		wait_for_idle();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
